### src/chgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package chgs_pkg;

  // Width of the coordinate fields on the ports.
  localparam int FIELD_W = 16;

  // Sets below this size bypass the hull and are emitted as loaded.
  localparam int MIN_HULL = 3;

  // Write data source for the point store.
  typedef enum logic [1:0] {
    WSEL_IN,
    WSEL_RD,
    WSEL_PIV,
    WSEL_KEY
  } wsel_t;

  // Geometry of a compare: angle about the pivot, or turn about a stack vertex.
  typedef enum logic {
    MODE_ANGLE,
    MODE_TURN
  } cmp_mode_t;

  typedef struct packed {
    logic      pts_we;
    wsel_t     pts_wsel;
    logic      pts_re;
    logic      stk_we;
    logic      stk_re;
    logic      piv_ld;
    logic      key_ld;
    logic      top_ld_rd;
    logic      top_ld_key;
    logic      cmp_start;
    cmp_mode_t cmp_mode;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    logic rd_lower;
    logic cmp_done;
    logic cmp_before;
    logic cmp_turn_le;
  } sts_t;

endpackage
`default_nettype wire

### src/chgs_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface chgs_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [chgs_pkg::FIELD_W-1:0] point_x;
  logic signed [chgs_pkg::FIELD_W-1:0] point_y;
  logic                                final_point;

  modport source (output valid, output point_x, output point_y, output final_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input final_point,
                output ready);
endinterface

interface chgs_hull_if;
  logic                                valid;
  logic                                ready;
  logic signed [chgs_pkg::FIELD_W-1:0] hull_x;
  logic signed [chgs_pkg::FIELD_W-1:0] hull_y;
  logic                                final_vertex;
  logic                                overflowed;

  modport source (output valid, output hull_x, output hull_y, output final_vertex,
                  output overflowed, input ready);
  modport sink (input valid, input hull_x, input hull_y, input final_vertex,
                input overflowed, output ready);
endinterface
`default_nettype wire

### src/chgs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module chgs_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire chgs_pkg::cmd_t                      cmd,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       pts_waddr,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       pts_raddr,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       stk_waddr,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       stk_raddr,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       stk_wdata,
  output logic      [$clog2(MAX_POINTS)-1:0]       stk_rdata,
  input  wire logic signed [chgs_pkg::FIELD_W-1:0] in_x,
  input  wire logic signed [chgs_pkg::FIELD_W-1:0] in_y,
  output logic signed [chgs_pkg::FIELD_W-1:0]      out_x,
  output logic signed [chgs_pkg::FIELD_W-1:0]      out_y,
  output chgs_pkg::sts_t                           sts
);
  localparam int CW = COORD_BITS;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic [2*CW-1:0] pts_mem [MAX_POINTS];
  logic [IW-1:0]   stk_mem [MAX_POINTS];
  logic [2*CW-1:0] pts_rd;
  logic [2*CW-1:0] pts_wdata;
  logic signed [CW-1:0] rd_x, rd_y, piv_x, piv_y, key_x, key_y, top_x, top_y;
  logic signed [CW-1:0] cin_x, cin_y;
  logic signed [CW-1:0] o_x, o_y, u_x, u_y, v_x, v_y;
  logic signed [DW-1:0] dax, day, dbx, dby;
  logic [DW-1:0]        max, may, mbx, mby;
  logic signed [PW-1:0] prod0, prod1;
  logic signed [PW:0]   xprod;
  logic [DW:0]          l1a, l1b;
  logic [2:0]           stage;
  logic                 rd_lower;
  logic                 cmp_done_q, cmp_before_q, cmp_turn_le_q;

  // Coordinates are the low COORD_BITS bits of the field, sign-extended above it on output.
  assign cin_x = CW'($unsigned(in_x));
  assign cin_y = CW'($unsigned(in_y));
  assign rd_x  = pts_rd[CW-1:0];
  assign rd_y  = pts_rd[2*CW-1:CW];

  always_comb begin
    case (cmd.pts_wsel)
      chgs_pkg::WSEL_IN:  pts_wdata = {cin_y, cin_x};
      chgs_pkg::WSEL_RD:  pts_wdata = pts_rd;
      chgs_pkg::WSEL_PIV: pts_wdata = {piv_y, piv_x};
      default:            pts_wdata = {key_y, key_x};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pts_we) begin
      pts_mem[pts_waddr] <= pts_wdata;
    end
    if (cmd.pts_re) begin
      pts_rd <= pts_mem[pts_raddr];
    end
    if (cmd.stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (cmd.stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.piv_ld) begin
      piv_x <= rd_x;
      piv_y <= rd_y;
    end
    if (cmd.key_ld) begin
      key_x <= rd_x;
      key_y <= rd_y;
    end
    if (cmd.top_ld_rd) begin
      top_x <= rd_x;
      top_y <= rd_y;
    end else if (cmd.top_ld_key) begin
      top_x <= key_x;
      top_y <= key_y;
    end
    if (cmd.out_ld) begin
      out_x <= chgs_pkg::FIELD_W'(rd_x);
      out_y <= chgs_pkg::FIELD_W'(rd_y);
    end
  end

  assign rd_lower = (rd_y < piv_y) || ((rd_y == piv_y) && (rd_x < piv_x));

  assign sts = '{rd_lower: rd_lower, cmp_done: cmp_done_q, cmp_before: cmp_before_q,
                 cmp_turn_le: cmp_turn_le_q};

  // Angle: origin pivot, key against the stored neighbor. Turn: origin stack vertex.
  always_comb begin
    if (cmd.cmp_mode == chgs_pkg::MODE_ANGLE) begin
      o_x = piv_x; o_y = piv_y;
      u_x = key_x; u_y = key_y;
      v_x = rd_x;  v_y = rd_y;
    end else begin
      o_x = rd_x;  o_y = rd_y;
      u_x = top_x; u_y = top_y;
      v_x = key_x; v_y = key_y;
    end
  end

  assign max   = dax[DW-1] ? DW'(-dax) : DW'(dax);
  assign may   = day[DW-1] ? DW'(-day) : DW'(day);
  assign mbx   = dbx[DW-1] ? DW'(-dbx) : DW'(dbx);
  assign mby   = dby[DW-1] ? DW'(-dby) : DW'(dby);
  // Parallel vectors: L1 length orders them the same as squared length.
  assign l1a   = (DW+1)'(max) + (DW+1)'(may);
  assign l1b   = (DW+1)'(mbx) + (DW+1)'(mby);
  assign xprod = (PW+1)'(prod0) - (PW+1)'(prod1);

  // Four-step compare: differences, two products on one multiplier, sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= '0;
      cmp_done_q <= 1'b0;
    end else begin
      stage      <= {stage[1:0], cmd.cmp_start};
      cmp_done_q <= stage[2];
    end
    if (cmd.cmp_start) begin
      dax <= DW'(u_x) - DW'(o_x);
      day <= DW'(u_y) - DW'(o_y);
      dbx <= DW'(v_x) - DW'(o_x);
      dby <= DW'(v_y) - DW'(o_y);
    end
    if (stage[0]) begin
      prod0 <= dax * dby;
    end
    if (stage[1]) begin
      prod1 <= day * dbx;
    end
    if (stage[2]) begin
      cmp_before_q  <= (!xprod[PW] && (xprod != '0)) || ((xprod == '0) && (l1a < l1b));
      cmp_turn_le_q <= xprod[PW] || (xprod == '0);
    end
  end
endmodule
`default_nettype wire

### src/chgs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module chgs_ctrl #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_final,
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_final,
  output logic                               out_ovf,
  output chgs_pkg::cmd_t                     cmd,
  input  wire chgs_pkg::sts_t                sts,
  output logic [$clog2(MAX_POINTS)-1:0]      pts_waddr,
  output logic [$clog2(MAX_POINTS)-1:0]      pts_raddr,
  output logic [$clog2(MAX_POINTS)-1:0]      stk_waddr,
  output logic [$clog2(MAX_POINTS)-1:0]      stk_raddr,
  output logic [$clog2(MAX_POINTS)-1:0]      stk_wdata,
  input  wire logic [$clog2(MAX_POINTS)-1:0] stk_rdata
);
  localparam int IW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    LOAD, START, PV_RD0, PV_LD0, PV_RD, PV_CMP, SW_RD, SW_WR, SW_WR2,
    SO_RDK, SO_LDK, SO_RDJ, SO_CMP, SO_WAIT, SO_PUT,
    SC_INIT, SC_INIT2, SC_RDI, SC_LDI, SC_CHK, SC_RDA, SC_CMP, SC_WAIT,
    SC_PUSH, SC_PUSH2, EM_RDS, EM_RDP, EM_LD, EM_WAIT
  } state_t;

  state_t        state;
  logic [NW-1:0] cnt, i, j, d, k;
  logic [IW-1:0] pidx, topidx;
  logic          drop, short_set;
  logic [NW-1:0] total;

  assign in_ready = (state == LOAD);
  assign total    = short_set ? cnt : d;

  always_comb begin
    cmd       = '0;
    pts_waddr = cnt[IW-1:0];
    pts_raddr = i[IW-1:0];
    stk_waddr = d[IW-1:0];
    stk_raddr = IW'(d - 1'b1);
    stk_wdata = topidx;
    unique case (state)
      LOAD: begin
        cmd.pts_we   = in_valid && (cnt < NW'(MAX_POINTS));
        cmd.pts_wsel = chgs_pkg::WSEL_IN;
      end
      PV_RD0: begin
        cmd.pts_re = 1'b1;
        pts_raddr  = '0;
      end
      PV_LD0: cmd.piv_ld = 1'b1;
      PV_RD:  cmd.pts_re = 1'b1;
      PV_CMP: cmd.piv_ld = sts.rd_lower;
      SW_RD: begin
        cmd.pts_re = 1'b1;
        pts_raddr  = '0;
      end
      SW_WR: begin
        cmd.pts_we   = 1'b1;
        cmd.pts_wsel = chgs_pkg::WSEL_RD;
        pts_waddr    = pidx;
      end
      SW_WR2: begin
        cmd.pts_we   = 1'b1;
        cmd.pts_wsel = chgs_pkg::WSEL_PIV;
        pts_waddr    = '0;
      end
      SO_RDK: cmd.pts_re = 1'b1;
      SO_LDK: cmd.key_ld = 1'b1;
      SO_RDJ: begin
        cmd.pts_re = 1'b1;
        pts_raddr  = IW'(j - 1'b1);
      end
      SO_CMP: begin
        cmd.cmp_start = 1'b1;
        cmd.cmp_mode  = chgs_pkg::MODE_ANGLE;
      end
      SO_WAIT: begin
        cmd.cmp_mode = chgs_pkg::MODE_ANGLE;
        cmd.pts_we   = sts.cmp_done && sts.cmp_before;
        cmd.pts_wsel = chgs_pkg::WSEL_RD;
        pts_waddr    = j[IW-1:0];
      end
      SO_PUT: begin
        cmd.pts_we   = 1'b1;
        cmd.pts_wsel = chgs_pkg::WSEL_KEY;
        pts_waddr    = j[IW-1:0];
      end
      SC_INIT: begin
        cmd.stk_we = 1'b1;
        stk_waddr  = '0;
        stk_wdata  = '0;
        cmd.pts_re = 1'b1;
        pts_raddr  = IW'(1);
      end
      SC_INIT2: cmd.top_ld_rd = 1'b1;
      SC_RDI:   cmd.pts_re = 1'b1;
      SC_LDI:   cmd.key_ld = 1'b1;
      SC_CHK:   cmd.stk_re = (d != '0);
      SC_RDA: begin
        cmd.pts_re = 1'b1;
        pts_raddr  = stk_rdata;
      end
      SC_CMP: begin
        cmd.cmp_start = 1'b1;
        cmd.cmp_mode  = chgs_pkg::MODE_TURN;
      end
      SC_WAIT: begin
        cmd.cmp_mode  = chgs_pkg::MODE_TURN;
        cmd.top_ld_rd = sts.cmp_done && sts.cmp_turn_le;
      end
      SC_PUSH: cmd.stk_we = 1'b1;
      SC_PUSH2: begin
        cmd.stk_we     = 1'b1;
        stk_wdata      = i[IW-1:0];
        cmd.top_ld_key = (i + 1'b1 != cnt);
      end
      EM_RDS: begin
        cmd.stk_re = 1'b1;
        stk_raddr  = k[IW-1:0];
      end
      EM_RDP: begin
        cmd.pts_re = 1'b1;
        pts_raddr  = short_set ? k[IW-1:0] : stk_rdata;
      end
      EM_LD: cmd.out_ld = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      cnt       <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
      d         <= '0;
    end else begin
      unique case (state)
        LOAD: begin
          if (in_valid) begin
            if (cnt < NW'(MAX_POINTS)) begin
              cnt <= cnt + 1'b1;
            end else begin
              drop <= 1'b1;
            end
            if (in_final) begin
              state <= START;
            end
          end
        end
        START: begin
          short_set <= (cnt < NW'(chgs_pkg::MIN_HULL));
          k         <= '0;
          state     <= (cnt < NW'(chgs_pkg::MIN_HULL)) ? EM_RDP : PV_RD0;
        end
        PV_RD0: state <= PV_LD0;
        PV_LD0: begin
          pidx  <= '0;
          i     <= NW'(1);
          state <= PV_RD;
        end
        PV_RD: state <= PV_CMP;
        PV_CMP: begin
          if (sts.rd_lower) begin
            pidx <= i[IW-1:0];
          end
          if (i + 1'b1 == cnt) begin
            state <= SW_RD;
          end else begin
            i     <= i + 1'b1;
            state <= PV_RD;
          end
        end
        SW_RD: state <= SW_WR;
        SW_WR: state <= SW_WR2;
        SW_WR2: begin
          i     <= NW'(2);
          state <= SO_RDK;
        end
        SO_RDK: state <= SO_LDK;
        SO_LDK: begin
          j     <= i;
          state <= SO_RDJ;
        end
        SO_RDJ: state <= (j > NW'(1)) ? SO_CMP : SO_PUT;
        SO_CMP: state <= SO_WAIT;
        SO_WAIT: begin
          if (sts.cmp_done) begin
            if (sts.cmp_before) begin
              j     <= j - 1'b1;
              state <= SO_RDJ;
            end else begin
              state <= SO_PUT;
            end
          end
        end
        SO_PUT: begin
          if (i + 1'b1 == cnt) begin
            state <= SC_INIT;
          end else begin
            i     <= i + 1'b1;
            state <= SO_RDK;
          end
        end
        SC_INIT: begin
          d      <= NW'(1);
          topidx <= IW'(1);
          i      <= NW'(2);
          state  <= SC_INIT2;
        end
        SC_INIT2: state <= SC_RDI;
        SC_RDI:   state <= SC_LDI;
        SC_LDI:   state <= SC_CHK;
        SC_CHK:   state <= (d != '0) ? SC_RDA : SC_PUSH;
        SC_RDA:   state <= SC_CMP;
        SC_CMP:   state <= SC_WAIT;
        SC_WAIT: begin
          if (sts.cmp_done) begin
            if (sts.cmp_turn_le) begin
              // pop: the vertex under the top becomes the new top
              topidx <= stk_rdata;
              d      <= d - 1'b1;
              state  <= SC_CHK;
            end else begin
              state <= SC_PUSH;
            end
          end
        end
        SC_PUSH: begin
          d     <= d + 1'b1;
          state <= SC_PUSH2;
        end
        SC_PUSH2: begin
          if (i + 1'b1 == cnt) begin
            d     <= d + 1'b1;
            k     <= '0;
            state <= EM_RDS;
          end else begin
            // push point i then pop it again: it is simply the new top
            topidx <= i[IW-1:0];
            i      <= i + 1'b1;
            state  <= SC_RDI;
          end
        end
        EM_RDS: state <= EM_RDP;
        EM_RDP: state <= EM_LD;
        EM_LD: begin
          out_valid <= 1'b1;
          out_final <= (k + 1'b1 == total);
          out_ovf   <= drop;
          state     <= EM_WAIT;
        end
        EM_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_final) begin
              cnt   <= '0;
              drop  <= 1'b0;
              d     <= '0;
              state <= LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= short_set ? EM_RDP : EM_RDS;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/convex_hull_graham_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: one point beat per cycle while the set is open.
// Hull: after the final point, pivot search, insertion-sort steps and stack pops on the shared
// compare unit; at most O(n^2).
// Emit: vertex beats from the registered store port (and hull stack), each read after the last is taken.
// Reset (rst, synchronous): empty set, no drop flag, output idle; store contents not cleared.
module convex_hull_graham_scan #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input wire logic       clk,
  input wire logic       rst,
  chgs_point_if.sink     points,
  chgs_hull_if.source    hull
);
  localparam int IW = $clog2(MAX_POINTS);

  chgs_pkg::cmd_t cmd;
  chgs_pkg::sts_t sts;
  logic [IW-1:0]  pts_waddr, pts_raddr, stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // Controller: owns counters, stack depth, handshakes and the step sequence.
  chgs_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_final  (points.final_point),
    .in_ready  (points.ready),
    .out_valid (hull.valid),
    .out_ready (hull.ready),
    .out_final (hull.final_vertex),
    .out_ovf   (hull.overflowed),
    .cmd       (cmd),
    .sts       (sts),
    .pts_waddr (pts_waddr),
    .pts_raddr (pts_raddr),
    .stk_waddr (stk_waddr),
    .stk_raddr (stk_raddr),
    .stk_wdata (stk_wdata),
    .stk_rdata (stk_rdata)
  );

  // Datapath: point store, hull stack, pivot/key/top registers, exact compare unit.
  chgs_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pts_waddr (pts_waddr),
    .pts_raddr (pts_raddr),
    .stk_waddr (stk_waddr),
    .stk_raddr (stk_raddr),
    .stk_wdata (stk_wdata),
    .stk_rdata (stk_rdata),
    .in_x      (points.point_x),
    .in_y      (points.point_y),
    .out_x     (hull.hull_x),
    .out_y     (hull.hull_y),
    .sts       (sts)
  );

  // Never take a point while a vertex beat is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(points.ready && hull.valid))
    else $error("input open while output valid");

  // A final point closes the input until the hull is out.
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready && points.final_point |=> !points.ready)
    else $error("input still open after final point");

  // After the last vertex beat, no further beat of the same set follows.
  a_last_vertex: assert property (@(posedge clk) disable iff (rst)
    hull.valid && hull.ready && hull.final_vertex |=> !hull.valid)
    else $error("beat after final vertex");
endmodule
`default_nettype wire

### tb/sv/convex_hull_graham_scan_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module convex_hull_graham_scan_checker #(
  parameter int MAX_POINTS = 64
) (
  input wire logic clk,
  input wire logic rst,
  chgs_point_if    points,
  chgs_hull_if     hull,
  output int       errors,
  output int       pending,
  output int       vertices
);

  typedef struct {
    logic signed [chgs_pkg::FIELD_W-1:0] x;
    logic signed [chgs_pkg::FIELD_W-1:0] y;
    logic                                last;
    logic                                ovf;
  } vertex_t;

  vertex_t hull_expect_q[$];

  longint px[MAX_POINTS];
  longint py[MAX_POINTS];
  int     set_count;
  logic   set_dropped;
  int     expected_total;

  assign pending = expected_total - vertices;

  function automatic void swap_points(int i, int j);
    longint tx, ty;
    tx = px[i];
    ty = py[i];
    px[i] = px[j];
    py[i] = py[j];
    px[j] = tx;
    py[j] = ty;
  endfunction

  // Angular order about the pivot; equal angles put the nearer point first.
  function automatic bit precedes(int p, int q);
    longint ax, ay, bx, by, c;
    ax = px[p] - px[0];
    ay = py[p] - py[0];
    bx = px[q] - px[0];
    by = py[q] - py[0];
    c = ax * by - ay * bx;
    if (c != 0) return c > 0;
    return (ax * ax + ay * ay) < (bx * bx + by * by);
  endfunction

  function automatic longint turn_of(int a, int b, int c);
    return (px[b] - px[a]) * (py[c] - py[a]) - (py[b] - py[a]) * (px[c] - px[a]);
  endfunction

  function automatic void queue_vertex(int idx, bit last);
    vertex_t v;
    v.x = px[idx][chgs_pkg::FIELD_W-1:0];
    v.y = py[idx][chgs_pkg::FIELD_W-1:0];
    v.last = last;
    v.ovf = set_dropped;
    hull_expect_q = {hull_expect_q, v};
    expected_total = expected_total + 1;
  endfunction

  // Reduce the stored set to its hull and queue one vertex per result.
  function automatic void predict_hull();
    int n, piv, depth, top;
    int stk[MAX_POINTS];
    n = set_count;
    if (n < chgs_pkg::MIN_HULL) begin
      for (int i = 0; i < n; i++) queue_vertex(i, i == n - 1);
      return;
    end
    piv = 0;
    for (int i = 1; i < n; i++)
      if (py[i] < py[piv] || (py[i] == py[piv] && px[i] < px[piv])) piv = i;
    swap_points(0, piv);
    for (int i = 2; i < n; i++)
      for (int j = i; j > 1 && precedes(j, j - 1); j--) swap_points(j, j - 1);
    stk[0] = 0;
    stk[1] = 1;
    depth = 2;
    for (int i = 2; i < n; i++) begin
      depth--;
      top = stk[depth];
      while (depth > 0 && turn_of(stk[depth - 1], top, i) <= 0) begin
        depth--;
        top = stk[depth];
      end
      stk[depth++] = top;
      stk[depth++] = i;
    end
    for (int i = 0; i < depth; i++) queue_vertex(stk[i], i == depth - 1);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      set_count = 0;
      set_dropped = 1'b0;
      expected_total = 0;
    end else if (points.valid && points.ready) begin
      if (set_count < MAX_POINTS) begin
        px[set_count] = longint'(points.point_x);
        py[set_count] = longint'(points.point_y);
        set_count = set_count + 1;
      end else begin
        set_dropped = 1'b1;
      end
      if (points.final_point) begin
        predict_hull();
        set_count = 0;
        set_dropped = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    vertex_t e;
    if (rst) begin
      errors = 0;
      vertices = 0;
    end else if (hull.valid && hull.ready) begin
      vertices++;
      if (hull_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex x=%0d y=%0d last=%0b ovf=%0b", $time,
                 hull.hull_x, hull.hull_y, hull.final_vertex, hull.overflowed);
      end else begin
        e = hull_expect_q.pop_front();
        if (e.x !== hull.hull_x || e.y !== hull.hull_y ||
            e.last !== hull.final_vertex || e.ovf !== hull.overflowed) begin
          errors++;
          $display("%0t: vertex mismatch expected x=%0d y=%0d last=%0b ovf=%0b", $time,
                   e.x, e.y, e.last, e.ovf);
          $display("%0t:                 actual   x=%0d y=%0d last=%0b ovf=%0b", $time,
                   hull.hull_x, hull.hull_y, hull.final_vertex, hull.overflowed);
        end
      end
    end
  end

endmodule
`default_nettype wire

### tb/sv/convex_hull_graham_scan_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module convex_hull_graham_scan_tb;

  localparam int MAX_PTS   = 64;
  localparam int IDLE_PCT  = 27;
  // Longest legal silence: a full 64-point sort plus scan, many times over.
  localparam int STALL_MAX = 200000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               fin;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  chgs_point_if points ();
  chgs_hull_if  hull ();

  int errors, pending, vertices;
  int sets_sent, points_sent, big_sets;
  bit steady;         // no idling on either side while set
  point_t point_q[$];
  int stall_cycles;

  convex_hull_graham_scan #(.MAX_POINTS(MAX_PTS), .COORD_BITS(16)) uut (
    .clk(clk), .rst(rst), .points(points.sink), .hull(hull.source)
  );

  convex_hull_graham_scan_checker #(.MAX_POINTS(MAX_PTS)) chk (
    .clk(clk), .rst(rst), .points(points), .hull(hull),
    .errors(errors), .pending(pending), .vertices(vertices)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Point driver: advance to the next beat once the current one is taken,
  // or hold a random gap.
  always @(posedge clk) begin
    point_t p;
    if (rst) begin
      points.valid <= 1'b0;
      points.point_x <= '0;
      points.point_y <= '0;
      points.final_point <= 1'b0;
    end else if (!points.valid || points.ready) begin
      if (point_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        p = point_q.pop_front();
        points.valid <= 1'b1;
        points.point_x <= p.x;
        points.point_y <= p.y;
        points.final_point <= p.fin;
      end else begin
        points.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall at random except during steady stretches.
  always @(posedge clk) begin
    if (rst) hull.ready <= 1'b0;
    else hull.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (points.valid && points.ready) || (hull.valid && hull.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("watchdog: no beat for %0d cycles", STALL_MAX);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic add_point(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic fin);
    point_t p;
    p.x = x;
    p.y = y;
    p.fin = fin;
    point_q = {point_q, p};
    points_sent++;
    if (fin) sets_sent++;
  endtask

  function automatic logic signed [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(8)) - 4);
      default: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic random_set();
    int n, mode, r;
    r = $urandom_range(99);
    if (r < 10) n = $urandom_range(2, 1);
    else if (r < 96 || big_sets >= 3) n = $urandom_range(9, 3);
    else begin
      n = $urandom_range(MAX_PTS + 4, MAX_PTS - 4);
      big_sets++;
    end
    mode = $urandom_range(2);
    for (int i = 0; i < n; i++) add_point(pick_coord(mode), pick_coord(mode), i == n - 1);
  endtask

  initial begin
    steady = 1'b0;
    sets_sent = 0;
    points_sent = 0;
    big_sets = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Single point, then a pair at opposite corners: both bypass the hull.
    add_point(16'sd5, 16'sd5, 1'b1);
    add_point(16'sh7fff, 16'sh8000, 1'b0);
    add_point(16'sh8000, 16'sh7fff, 1'b1);
    // Square with collinear edge points, an interior point and duplicates,
    // one of them equal to the pivot.
    add_point(16'sd10, 16'sd10, 1'b0);
    add_point(16'sd0, 16'sd0, 1'b0);
    add_point(16'sd10, 16'sd0, 1'b0);
    add_point(16'sd5, 16'sd0, 1'b0);
    add_point(16'sd0, 16'sd10, 1'b0);
    add_point(16'sd5, 16'sd5, 1'b0);
    add_point(16'sd0, 16'sd0, 1'b0);
    add_point(16'sd10, 16'sd10, 1'b1);
    // Full-range corners: widest differences and products.
    add_point(16'sh0000, 16'sh0000, 1'b0);
    add_point(16'sh7fff, 16'sh7fff, 1'b0);
    add_point(16'sh8000, 16'sh8000, 1'b0);
    add_point(16'sh7fff, 16'sh8000, 1'b0);
    add_point(16'sh8000, 16'sh7fff, 1'b1);
    // All points on one line.
    add_point(16'sd3, 16'sd3, 1'b0);
    add_point(16'sd1, 16'sd1, 1'b0);
    add_point(16'sd0, 16'sd0, 1'b0);
    add_point(16'sd2, 16'sd2, 1'b1);

    // Random sets; a steady stretch with no idling in the middle.
    while (points_sent < 280) begin
      steady = (points_sent > 120 && points_sent < 170);
      random_set();
      wait (point_q.size() == 0);
    end
    steady = 1'b0;

    wait (point_q.size() == 0);
    @(posedge clk);
    while (points.valid) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d sets, %0d points, %0d hull vertices, %0d sets at capacity",
             sets_sent, points_sent, vertices, big_sets);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d vertices missing", errors, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
